/* src/clws_pkg.sv */
// ----------------------------------------------------------------------------
// clws_pkg
// Types, codes and constants shared by the character LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clws_pkg;

    localparam int STROBE_W   = 8;
    localparam int WAIT_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 4;
    localparam int INIT_LEN   = 9;

    localparam logic [STROBE_W-1:0] STROBE_RESET = 8'd16;
    localparam logic [WAIT_W-1:0]   WAIT_RESET   = 16'd15000;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] LINE_TWO_CMD = 8'h80 | 8'h40;

    localparam logic [0:0] REG_STROBE = 1'b0;
    localparam logic [0:0] REG_WAIT   = 1'b1;

    localparam logic [1:0] OPC_TICK = 2'd0;
    localparam logic [1:0] OPC_CHAR = 2'd1;
    localparam logic [1:0] OPC_END  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CHAR,
        OP_END,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_EHIGH,
        PH_ELOW,
        PH_WAIT,
        PH_END
    } t_phase;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic       starts_text;
    } t_item;

    typedef struct packed {
        logic       register_select_pin;
        logic [7:0] data_pins;
        logic       enable_pin;
        logic       backlight_pin;
        logic       ready_res;
        logic       accepted;
    } t_result;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

    function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step);
        logic [7:0] cmd;
        unique case (step)
            4'd0:    cmd = 8'h30;
            4'd1:    cmd = 8'h30;
            4'd2:    cmd = 8'h30;
            4'd3:    cmd = 8'h38;
            4'd4:    cmd = 8'h08;
            4'd5:    cmd = 8'h01;
            4'd6:    cmd = 8'h06;
            4'd7:    cmd = 8'h0c;
            4'd8:    cmd = 8'h02;
            default: cmd = 8'h30;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

/* src/clws_queue.sv */
// ----------------------------------------------------------------------------
// clws_queue
// Two-entry queue; push and pop may complete in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_queue #(
    parameter int W = clws_pkg::ITEM_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    logic [W-1:0] r_mem [0:1];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         wr_fire;
    logic         rd_fire;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_fire = i_push && !o_full;
    assign rd_fire = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_fire) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 2'd1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/clws_front.sv */
// ----------------------------------------------------------------------------
// clws_front
// Input side: decode the operation code and queue items for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [1:0]    i_operation,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_starts_text,
    output logic               o_full,
    input  wire logic          i_pop,
    output clws_pkg::t_item    o_item,
    output logic               o_empty
);
    import clws_pkg::*;

    t_item in_item;

    always_comb begin
        unique case (i_operation)
            OPC_TICK: in_item.op = OP_TICK;
            OPC_CHAR: in_item.op = OP_CHAR;
            OPC_END:  in_item.op = OP_END;
            default:  in_item.op = OP_NONE;
        endcase
        in_item.char_code   = i_char_code;
        in_item.starts_text = i_starts_text;
    end

    clws_queue #(
        .W(ITEM_W)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (in_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

/* src/clws_back.sv */
// ----------------------------------------------------------------------------
// clws_back
// Sequencer: executes one queued item per cycle while the result queue has
// room, drives the pin state and emits one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [clws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire clws_pkg::t_item            i_item,
    input  wire logic                       i_item_empty,
    output logic                            o_item_pop,
    input  wire logic                       i_res_full,
    output logic                            o_res_push,
    output clws_pkg::t_result               o_result
);
    import clws_pkg::*;

    logic [STROBE_W-1:0] r_strobe;
    logic [WAIT_W-1:0]   r_wait;
    t_phase              r_phase, n_phase;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [WAIT_W-1:0]   r_tick, n_tick;
    logic [7:0]          r_held, n_held;
    logic                r_is_data, n_is_data;
    logic                r_pending, n_pending;
    logic                r_backlight, n_backlight;
    logic [7:0]          r_pins, n_pins;

    logic                fire;
    logic                taken;
    logic [WAIT_W-1:0]   tick_next;
    logic [WAIT_W-1:0]   limit;
    logic                done;
    logic [STEP_W-1:0]   step_next;

    assign fire       = !i_item_empty && !i_res_full;
    assign o_item_pop = fire;
    assign o_res_push = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= STROBE_RESET;
            r_wait   <= WAIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_STROBE: r_strobe <= i_cfg_data[STROBE_W-1:0];
                REG_WAIT:   r_wait   <= i_cfg_data[WAIT_W-1:0];
                default:    r_wait   <= r_wait;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_tick      <= '0;
            r_held      <= '0;
            r_is_data   <= 1'b0;
            r_pending   <= 1'b0;
            r_backlight <= 1'b0;
            r_pins      <= '0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_tick      <= n_tick;
            r_held      <= n_held;
            r_is_data   <= n_is_data;
            r_pending   <= n_pending;
            r_backlight <= n_backlight;
            r_pins      <= n_pins;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_tick      = r_tick;
        n_held      = r_held;
        n_is_data   = r_is_data;
        n_pending   = r_pending;
        n_backlight = r_backlight;
        n_pins      = r_pins;
        taken       = 1'b0;

        tick_next = r_tick + 1'b1;
        limit     = ((r_phase == PH_EHIGH) || (r_phase == PH_ELOW))
                    ? {{(WAIT_W-STROBE_W){1'b0}}, r_strobe} : r_wait;
        done      = (tick_next >= limit) || (tick_next == '0);
        step_next = r_step + 1'b1;

        unique case (i_item.op)
            OP_TICK: begin
                unique case (r_phase)
                    PH_START: begin
                        n_tick = done ? '0 : tick_next;
                        if (done) begin
                            n_step    = '0;
                            n_is_data = 1'b0;
                            n_pins    = init_cmd('0);
                            n_phase   = PH_EHIGH;
                        end
                    end
                    PH_EHIGH: begin
                        n_tick = done ? '0 : tick_next;
                        if (done) begin
                            n_phase = PH_ELOW;
                        end
                    end
                    PH_ELOW: begin
                        n_tick = done ? '0 : tick_next;
                        if (done) begin
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        n_tick = done ? '0 : tick_next;
                        if (done) begin
                            if (r_pending) begin
                                n_phase = PH_EHIGH;
                                if (step_next < STEP_W'(INIT_LEN)) begin
                                    n_step    = step_next;
                                    n_is_data = 1'b0;
                                    n_pins    = init_cmd(step_next);
                                end else begin
                                    n_step    = '0;
                                    n_pending = 1'b0;
                                    if (r_held == NEWLINE_CODE) begin
                                        n_is_data = 1'b0;
                                        n_pins    = LINE_TWO_CMD;
                                    end else begin
                                        n_is_data = 1'b1;
                                        n_pins    = r_held;
                                    end
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_END: begin
                        n_tick = done ? '0 : tick_next;
                        if (done) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            OP_CHAR: begin
                if (r_phase == PH_IDLE) begin
                    taken  = 1'b1;
                    n_held = i_item.char_code;
                    n_tick = '0;
                    if (i_item.starts_text) begin
                        n_is_data   = 1'b0;
                        n_pins      = '0;
                        n_backlight = 1'b1;
                        n_step      = '0;
                        n_pending   = 1'b1;
                        n_phase     = PH_START;
                    end else begin
                        n_pending = 1'b0;
                        n_phase   = PH_EHIGH;
                        if (i_item.char_code == NEWLINE_CODE) begin
                            n_is_data = 1'b0;
                            n_pins    = LINE_TWO_CMD;
                        end else begin
                            n_is_data = 1'b1;
                            n_pins    = i_item.char_code;
                        end
                    end
                end
            end
            OP_END: begin
                if (r_phase == PH_IDLE) begin
                    taken   = 1'b1;
                    n_tick  = '0;
                    n_phase = PH_END;
                end
            end
            default: begin
                taken = 1'b0;
            end
        endcase

        o_result.register_select_pin = n_is_data;
        o_result.data_pins           = n_pins;
        o_result.enable_pin          = (n_phase == PH_EHIGH);
        o_result.backlight_pin       = n_backlight;
        o_result.ready_res           = (n_phase == PH_IDLE);
        o_result.accepted            = taken;
    end

endmodule

`default_nettype wire

/* src/character_lcd_write_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// character_lcd_write_sequencer_unit
// 8-bit parallel character LCD write sequencer with queued item and result
// channels and a two-register configuration port.
//
//   channel   direction  handshake          payload
//   item      in         push / full        i_operation, i_char_code,
//                                           i_starts_text
//   result    out        pop / empty        o_register_select_pin,
//                                           o_data_pins, o_enable_pin,
//                                           o_backlight_pin, o_ready_res,
//                                           o_accepted
//   config    in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// One item per clock sustained while neither side stalls: the sequencer
// executes one item per cycle while one waits and the result queue has room.
// A result is queued as its item is popped and can be popped once shown.
// Synchronous active-low reset empties both queues and restores the pin
// state and register defaults.
// Either side may stall; each two-entry queue buffers up to two items.
// ----------------------------------------------------------------------------
`default_nettype none

module character_lcd_write_sequencer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [7:0]                      i_char_code,
    input  wire logic                            i_starts_text,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 o_register_select_pin,
    output logic [7:0]                           o_data_pins,
    output logic                                 o_enable_pin,
    output logic                                 o_backlight_pin,
    output logic                                 o_ready_res,
    output logic                                 o_accepted,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [0:0]                      i_cfg_index,
    input  wire logic [clws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clws_pkg::*;

    t_item   item;
    logic    item_empty;
    logic    item_pop;
    logic    res_full;
    logic    res_push;
    t_result res_in;
    t_result res_out;

    clws_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_operation   (i_operation),
        .i_char_code   (i_char_code),
        .i_starts_text (i_starts_text),
        .o_full        (full),
        .i_pop         (item_pop),
        .o_item        (item),
        .o_empty       (item_empty)
    );

    clws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_result     (res_in)
    );

    clws_queue #(
        .W(RESULT_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_register_select_pin = res_out.register_select_pin;
    assign o_data_pins           = res_out.data_pins;
    assign o_enable_pin          = res_out.enable_pin;
    assign o_backlight_pin       = res_out.backlight_pin;
    assign o_ready_res           = res_out.ready_res;
    assign o_accepted            = res_out.accepted;

endmodule

`default_nettype wire

/* src/clws_checker.sv */
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks on the result channel of the LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_data_pins,
    input wire logic       o_enable_pin,
    input wire logic       o_backlight_pin,
    input wire logic       o_ready_res,
    input wire logic       o_accepted
);

    a_strobe_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_enable_pin) |-> !o_ready_res)
        else $error("enable strobe high while sequencer reports idle");

    a_taken_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted) |-> !o_ready_res)
        else $error("accepted transaction left sequencer idle");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_pins)))
        else $error("stalled result changed or vanished");

    a_backlight_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_backlight_pin) |=> (empty || o_backlight_pin))
        else $error("backlight switched off after being on");

endmodule

bind character_lcd_write_sequencer_unit clws_checker u_clws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_data_pins     (o_data_pins),
    .o_enable_pin    (o_enable_pin),
    .o_backlight_pin (o_backlight_pin),
    .o_ready_res     (o_ready_res),
    .o_accepted      (o_accepted)
);

`default_nettype wire
